// ===== hdl/ssfs_pkg.sv =====
// Shared types, constants and table functions for the subband scale factor select block.
package ssfs_pkg;

    // Samples per part and the index used for an all-zero part.
    localparam int PART_LEN = 12;
    localparam logic [5:0] ZERO_INDEX = 6'd62;

    // Peaks are carried clamped to 22 bits; bit 21 set means overflow.
    localparam int PEAK_W = 22;
    localparam logic [PEAK_W-1:0] PEAK_OVER = 22'h200000;

    // Part numbers within a band.
    localparam logic [1:0] PART_FIRST = 2'd0;
    localparam logic [1:0] PART_LAST  = 2'd2;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Transmission pattern codes.
    localparam logic [1:0] TC_THREE       = 2'd0;
    localparam logic [1:0] TC_SHARE_FIRST = 2'd1;
    localparam logic [1:0] TC_ONE         = 2'd2;
    localparam logic [1:0] TC_SHARE_LAST  = 2'd3;

    // Reset value of the band count register.
    localparam logic [5:0] BANDS_RESET = 6'd32;

    // One finished part as it travels from front to back.
    typedef struct packed {
        logic [1:0]        part;
        logic [PEAK_W-1:0] peak;
    } part_rec_t;

    // One band result.
    typedef struct packed {
        logic       last;
        logic [1:0] code;
        logic [5:0] third;
        logic [5:0] second;
        logic [5:0] first;
    } band_res_t;

    // Threshold table: floor of the cube root of 2^(63-i), at least one.
    function automatic logic [PEAK_W-1:0] thr_lookup(input logic [5:0] idx);
        logic [PEAK_W-1:0] v;
        case (idx)
            6'd0:  v = 22'd2097152;
            6'd1:  v = 22'd1664510;
            6'd2:  v = 22'd1321122;
            6'd3:  v = 22'd1048576;
            6'd4:  v = 22'd832255;
            6'd5:  v = 22'd660561;
            6'd6:  v = 22'd524288;
            6'd7:  v = 22'd416127;
            6'd8:  v = 22'd330280;
            6'd9:  v = 22'd262144;
            6'd10: v = 22'd208063;
            6'd11: v = 22'd165140;
            6'd12: v = 22'd131072;
            6'd13: v = 22'd104031;
            6'd14: v = 22'd82570;
            6'd15: v = 22'd65536;
            6'd16: v = 22'd52015;
            6'd17: v = 22'd41285;
            6'd18: v = 22'd32768;
            6'd19: v = 22'd26007;
            6'd20: v = 22'd20642;
            6'd21: v = 22'd16384;
            6'd22: v = 22'd13003;
            6'd23: v = 22'd10321;
            6'd24: v = 22'd8192;
            6'd25: v = 22'd6501;
            6'd26: v = 22'd5160;
            6'd27: v = 22'd4096;
            6'd28: v = 22'd3250;
            6'd29: v = 22'd2580;
            6'd30: v = 22'd2048;
            6'd31: v = 22'd1625;
            6'd32: v = 22'd1290;
            6'd33: v = 22'd1024;
            6'd34: v = 22'd812;
            6'd35: v = 22'd645;
            6'd36: v = 22'd512;
            6'd37: v = 22'd406;
            6'd38: v = 22'd322;
            6'd39: v = 22'd256;
            6'd40: v = 22'd203;
            6'd41: v = 22'd161;
            6'd42: v = 22'd128;
            6'd43: v = 22'd101;
            6'd44: v = 22'd80;
            6'd45: v = 22'd64;
            6'd46: v = 22'd50;
            6'd47: v = 22'd40;
            6'd48: v = 22'd32;
            6'd49: v = 22'd25;
            6'd50: v = 22'd20;
            6'd51: v = 22'd16;
            6'd52: v = 22'd12;
            6'd53: v = 22'd10;
            6'd54: v = 22'd8;
            6'd55: v = 22'd6;
            6'd56: v = 22'd5;
            6'd57: v = 22'd4;
            6'd58: v = 22'd3;
            6'd59: v = 22'd2;
            6'd60: v = 22'd2;
            default: v = 22'd1;
        endcase
        return v;
    endfunction

    // Scale factor index of a clamped peak: coarse estimate from the top bit,
    // then up to three refinement steps against the threshold table.
    function automatic logic [5:0] peak_index(input logic [PEAK_W-1:0] peak);
        logic [4:0] n;
        logic [5:0] start;
        logic       q1;
        logic       q2;
        logic       q3;
        logic [5:0] idx;
        n = '0;
        for (int b = 1; b < PEAK_W - 1; b++) begin
            if (peak[b]) begin
                n = 5'(b);
            end
        end
        start = 6'd60 - 6'(3 * int'(n));
        q1 = (peak <= thr_lookup(start + 6'd1));
        q2 = (peak <= thr_lookup(start + 6'd2));
        // The index never climbs past the all-zero code.
        q3 = (start <= ZERO_INDEX - 6'd3) && (peak <= thr_lookup(start + 6'd3));
        if (peak == '0) begin
            idx = ZERO_INDEX;
        end else if (peak[PEAK_W-1]) begin
            idx = '0;
        end else begin
            idx = start + {5'd0, q1} + {5'd0, q1 & q2} + {5'd0, q1 & q2 & q3};
        end
        return idx;
    endfunction

    // Class of the difference a - b: 0 for <= -3, 1 for -2..-1, 2 for 0,
    // 3 for 1..2, 4 for >= 3.
    function automatic logic [2:0] diff_class(input logic [5:0] a, input logic [5:0] b);
        logic signed [6:0] d;
        logic [2:0]        c;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        if (d <= -7'sd3) begin
            c = 3'd0;
        end else if (d < 7'sd0) begin
            c = 3'd1;
        end else if (d == 7'sd0) begin
            c = 3'd2;
        end else if (d < 7'sd3) begin
            c = 3'd3;
        end else begin
            c = 3'd4;
        end
        return c;
    endfunction

endpackage

// ===== hdl/ssfs_front.sv =====
// Front part: takes samples, tracks the peak magnitude of each part and queues finished parts.
module ssfs_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [SAMPLE_BITS-1:0]  sample,
    input  logic                    q_full,
    output logic                    q_push,
    output ssfs_pkg::part_rec_t     q_data
);
    import ssfs_pkg::*;

    localparam int PW = (SAMPLE_BITS > PEAK_W) ? SAMPLE_BITS : PEAK_W;

    logic [3:0]             pos_reg;
    logic [1:0]             part_reg;
    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SAMPLE_BITS-1:0] peak_next;
    logic [PW-1:0]          peak_ext;
    logic                   accept;
    logic                   part_end;
    logic                   over;

    // A request is taken whenever the queue has room for a finished part.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign part_end = (pos_reg == 4'(PART_LEN - 1));

    // Magnitude; the most negative sample maps to 2^(SAMPLE_BITS-1).
    always_comb begin
        mag = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~sample + 1'b1) : sample;
        peak_next = ((pos_reg == '0) || (mag > peak_reg)) ? mag : peak_reg;
    end

    // Clamp the part peak to 22 bits, marking overflow with bit 21 alone.
    always_comb begin
        peak_ext    = PW'(peak_next);
        over        = |peak_ext[PW-1:PEAK_W-1];
        q_data.part = part_reg;
        q_data.peak = over ? PEAK_OVER : peak_ext[PEAK_W-1:0];
    end

    assign q_push = accept && part_end;

    // Sample and part counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            part_reg <= PART_FIRST;
        end else if (accept) begin
            if (part_end) begin
                pos_reg  <= '0;
                part_reg <= (part_reg == PART_LAST) ? PART_FIRST : part_reg + 2'd1;
            end else begin
                pos_reg <= pos_reg + 4'd1;
            end
        end
    end

    // Running peak of the current part.
    always_ff @(posedge aclk) begin
        if (accept) begin
            peak_reg <= peak_next;
        end
    end

endmodule

// ===== hdl/ssfs_queue.sv =====
// Short queue of finished parts between the front and the back.
module ssfs_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ssfs_pkg::part_rec_t  wr_data,
    output logic                 full,
    input  logic                 pop,
    output ssfs_pkg::part_rec_t  rd_data,
    output logic                 not_empty
);
    import ssfs_pkg::*;

    part_rec_t       mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;

    assign full      = (count_reg == (Q_AW + 1)'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/ssfs_back.sv =====
// Back part: turns part peaks into indices, applies the selection rule and holds the result.
module ssfs_back #(
    parameter int MAX_BANDS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  ssfs_pkg::part_rec_t  q_data,
    output logic                 q_pop,
    input  logic [5:0]           bands_in_use,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output ssfs_pkg::band_res_t  m_res
);
    import ssfs_pkg::*;

    localparam int BAND_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

    logic              st_valid_reg;
    logic [1:0]        st_part_reg;
    logic [5:0]        st_index_reg;
    logic [5:0]        s0_reg;
    logic [5:0]        s1_reg;
    logic [BAND_W-1:0] band_reg;
    logic              out_valid_reg;
    band_res_t         out_reg;

    logic              out_free;
    logic              st_last;
    logic              st_move;
    logic [2:0]        d1;
    logic [2:0]        d2;
    logic [4:0]        key;
    logic [5:0]        limit;
    logic [5:0]        band_inc;
    logic              last;
    logic [BAND_W-1:0] band_next;
    band_res_t         sel;

    // Stage handshake: parts 0 and 1 retire at once, part 2 waits for the output slot.
    assign out_free = !out_valid_reg || m_tready;
    assign st_last  = (st_part_reg == PART_LAST);
    assign st_move  = st_valid_reg && (!st_last || out_free);
    assign q_pop    = q_valid && (!st_valid_reg || st_move);

    // Band counting against the clamped band count.
    always_comb begin
        if (bands_in_use == '0) begin
            limit = 6'd1;
        end else if (bands_in_use > 6'(MAX_BANDS)) begin
            limit = 6'(MAX_BANDS);
        end else begin
            limit = bands_in_use;
        end
        band_inc  = 6'(band_reg) + 6'd1;
        last      = (band_inc >= limit);
        band_next = last ? '0 : band_inc[BAND_W-1:0];
    end

    // Difference classes and the 25-case selection rule, keyed by class1 * 5 + class2.
    always_comb begin
        d1  = diff_class(s0_reg, s1_reg);
        d2  = diff_class(s1_reg, st_index_reg);
        key = 5'(int'(d1) * 5 + int'(d2));
        sel.first  = s0_reg;
        sel.second = s1_reg;
        sel.third  = st_index_reg;
        sel.last   = last;
        case (key) inside
            5'd0, 5'd4, 5'd19, 5'd20, 5'd24: begin
                sel.code = TC_THREE;
            end
            5'd1, 5'd2, 5'd21, 5'd22: begin
                sel.code  = TC_SHARE_LAST;
                sel.third = s1_reg;
            end
            5'd3, 5'd23: begin
                sel.code   = TC_SHARE_LAST;
                sel.second = st_index_reg;
            end
            5'd5, 5'd9, 5'd14: begin
                sel.code   = TC_SHARE_FIRST;
                sel.second = s0_reg;
            end
            5'd6, 5'd7, 5'd10, 5'd11, 5'd12: begin
                sel.code   = TC_ONE;
                sel.second = s0_reg;
                sel.third  = s0_reg;
            end
            5'd13, 5'd18: begin
                sel.code   = TC_ONE;
                sel.first  = st_index_reg;
                sel.second = st_index_reg;
            end
            5'd15, 5'd16, 5'd17: begin
                sel.code  = TC_ONE;
                sel.first = s1_reg;
                sel.third = s1_reg;
            end
            default: begin
                // Falling then rising by a little: all three take the smaller outer index.
                sel.code = TC_ONE;
                if (s0_reg > st_index_reg) begin
                    sel.first = st_index_reg;
                end
                sel.second = sel.first;
                sel.third  = sel.first;
            end
        endcase
    end

    // Control state: stage occupancy, earlier part indices, band count, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            s0_reg        <= '0;
            s1_reg        <= '0;
            band_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                st_valid_reg <= 1'b1;
            end else if (st_move) begin
                st_valid_reg <= 1'b0;
            end
            if (st_move && !st_last) begin
                if (st_part_reg == PART_FIRST) begin
                    s0_reg <= st_index_reg;
                end else begin
                    s1_reg <= st_index_reg;
                end
            end
            if (st_move && st_last) begin
                out_valid_reg <= 1'b1;
                band_reg      <= band_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: index of the popped part and the held result.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            st_part_reg  <= q_data.part;
            st_index_reg <= peak_index(q_data.peak);
        end
        if (st_move && st_last) begin
            out_reg <= sel;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_res    = out_reg;

endmodule

// ===== hdl/subband_scale_factor_select_core.sv =====
// Top level of the subband scale factor select block: ports, band count register and checks.
//
// The block takes one subband sample per clock with no gaps required, 36 per band as three
// parts of 12. The front tracks each part's peak with one compare per sample, which sets the
// rate at one sample per cycle while the queue has room; each finished part goes through a
// four-entry queue to the back, which registers the part's scale factor index and, after the
// third part, applies the selection rule into an output register. A band result passes
// through the queue, the index stage and the output register, and is held until the sink
// takes it; the input keeps flowing while a result waits, and stalls only once four finished
// parts are queued. The band count register may be written only while no band is in flight.
module subband_scale_factor_select_core #(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_BANDS   = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Fields from bit 0: sample.
    input  logic [((SAMPLE_BITS + 7) / 8)*8-1:0] s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: first_scale_index, second_scale_index, third_scale_index,
    // transmit_code, zero fill.
    output logic [23:0]                          m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_wr_en,
    input  logic [5:0]                           cfg_wr_data
);
    import ssfs_pkg::*;

    logic [5:0] bands_reg;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_valid;
    part_rec_t  q_wr_data;
    part_rec_t  q_rd_data;
    band_res_t  res;

    // Band count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bands_reg <= BANDS_RESET;
        end else if (cfg_wr_en) begin
            bands_reg <= cfg_wr_data;
        end
    end

    ssfs_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sample  (s_tdata[SAMPLE_BITS-1:0]),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wr_data)
    );

    ssfs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .pop      (q_pop),
        .rd_data  (q_rd_data),
        .not_empty(q_valid)
    );

    ssfs_back #(
        .MAX_BANDS(MAX_BANDS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_data      (q_rd_data),
        .q_pop       (q_pop),
        .bands_in_use(bands_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_res       (res)
    );

    // Pack the result fields.
    assign m_tdata = {4'd0, res.code, res.third, res.second, res.first};
    assign m_tlast = res.last;

    // The front never queues a part into a full queue, and the back never pops an empty one.
    a_queue_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full) && !(q_pop && !q_valid))
        else $error("queue overflow or underflow");

    // A single shared scale factor means all three indices agree.
    a_code_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (res.code == TC_ONE)) |->
        ((res.first == res.second) && (res.second == res.third)))
        else $error("single scale factor code with differing indices");

    // Shared pairs match the code.
    a_code_pairs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
        (((res.code != TC_SHARE_FIRST) || (res.first == res.second)) &&
         ((res.code != TC_SHARE_LAST) || (res.second == res.third))))
        else $error("shared pair code with differing indices");

endmodule

// ===== bench/tb_subband_scale_factor_select_core.sv =====
// Self-checking testbench for the subband scale factor select core with a predicting scoreboard.
module tb_subband_scale_factor_select_core;
    import ssfs_pkg::*;

    localparam int SAMPLE_W      = 24;
    localparam int MAX_BANDS     = 32;
    localparam int OVER_BIT      = 21;
    localparam int BAND_SAMPLES  = 3 * PART_LEN;
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int PHASES        = 3;
    localparam int SEGMENTS      = 4;

    // Classes of the difference between two neighboring part indices.
    localparam logic [2:0] CL_DROP = 3'd0;
    localparam logic [2:0] CL_DOWN = 3'd1;
    localparam logic [2:0] CL_SAME = 3'd2;
    localparam logic [2:0] CL_UP   = 3'd3;
    localparam logic [2:0] CL_RISE = 3'd4;

    // Predicts band results from accepted samples and checks them in order.
    class band_scale_tracker;
        int unsigned thr_tab [64];
        logic [5:0]  band_count;
        int unsigned sample_pos;
        int unsigned band_pos;
        logic [23:0] peak_mag;
        logic [5:0]  part_idx [2];
        band_res_t   pending_bands [$];
        int          errors;

        function new();
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned mid;
            longint unsigned lim;
            // Floor of the cube root of 2^(63-i), never below one.
            for (int i = 0; i < 64; i++) begin
                lo  = 0;
                hi  = (64'd1 << 21) + 1;
                lim = 64'd1 << (63 - i);
                while (hi - lo > 1) begin
                    mid = (lo + hi) / 2;
                    if (mid * mid * mid <= lim) begin
                        lo = mid;
                    end else begin
                        hi = mid;
                    end
                end
                thr_tab[i] = (lo == 0) ? 1 : int'(lo);
            end
            band_count  = BANDS_RESET;
            sample_pos  = 0;
            band_pos    = 0;
            peak_mag    = '0;
            part_idx[0] = '0;
            part_idx[1] = '0;
            errors      = 0;
        endfunction

        function int pending();
            return pending_bands.size();
        endfunction

        function void set_band_count(logic [5:0] v);
            band_count = v;
        endfunction

        // Coarse index from the top bit, then walk down the threshold table.
        function logic [5:0] index_of_peak(logic [23:0] peak);
            int          n;
            int unsigned ix;
            if (peak == '0) begin
                return ZERO_INDEX;
            end
            n = 0;
            for (int b = 1; b < SAMPLE_W; b++) begin
                if (peak[b]) begin
                    n = b;
                end
            end
            if (n >= OVER_BIT) begin
                return '0;
            end
            ix = (OVER_BIT - n) * 3 - 3;
            while (ix < ZERO_INDEX && peak <= thr_tab[ix + 1]) begin
                ix++;
            end
            return 6'(ix);
        endfunction

        function logic [2:0] class_of(logic [5:0] a, logic [5:0] b);
            int d;
            d = int'(a) - int'(b);
            if (d <= -3) begin
                return CL_DROP;
            end else if (d < 0) begin
                return CL_DOWN;
            end else if (d == 0) begin
                return CL_SAME;
            end else if (d < 3) begin
                return CL_UP;
            end
            return CL_RISE;
        endfunction

        // Track the part peak; after the 36th sample of a band, predict its result.
        function void note_sample(logic [23:0] raw);
            logic [23:0] mag;
            int unsigned pos;
            int unsigned part;
            logic [5:0]  s0;
            logic [5:0]  s1;
            logic [5:0]  s2;
            logic [2:0]  c1;
            logic [2:0]  c2;
            logic [1:0]  tcode;
            int unsigned lim;
            band_res_t   r;
            mag  = raw[SAMPLE_W-1] ? -raw : raw;
            pos  = sample_pos % PART_LEN;
            part = sample_pos / PART_LEN;
            if (pos == 0 || mag > peak_mag) begin
                peak_mag = mag;
            end
            if (pos != PART_LEN - 1) begin
                sample_pos++;
                return;
            end
            if (part < 2) begin
                part_idx[part] = index_of_peak(peak_mag);
                sample_pos++;
                return;
            end
            s0 = part_idx[0];
            s1 = part_idx[1];
            s2 = index_of_peak(peak_mag);
            c1 = class_of(s0, s1);
            c2 = class_of(s1, s2);
            // Layer II selection rule over the 25 class pairs.
            case ({c1, c2})
                {CL_DROP, CL_DROP}, {CL_DROP, CL_RISE}, {CL_UP, CL_RISE},
                {CL_RISE, CL_DROP}, {CL_RISE, CL_RISE}: begin
                    tcode = TC_THREE;
                end
                {CL_DROP, CL_DOWN}, {CL_DROP, CL_SAME}, {CL_RISE, CL_DOWN},
                {CL_RISE, CL_SAME}: begin
                    tcode = TC_SHARE_LAST;
                    s2 = s1;
                end
                {CL_DROP, CL_UP}, {CL_RISE, CL_UP}: begin
                    tcode = TC_SHARE_LAST;
                    s1 = s2;
                end
                {CL_DOWN, CL_DROP}, {CL_DOWN, CL_RISE}, {CL_SAME, CL_RISE}: begin
                    tcode = TC_SHARE_FIRST;
                    s1 = s0;
                end
                {CL_DOWN, CL_DOWN}, {CL_DOWN, CL_SAME}, {CL_SAME, CL_DROP},
                {CL_SAME, CL_DOWN}, {CL_SAME, CL_SAME}: begin
                    tcode = TC_ONE;
                    s1 = s0;
                    s2 = s0;
                end
                {CL_SAME, CL_UP}, {CL_UP, CL_UP}: begin
                    tcode = TC_ONE;
                    s0 = s2;
                    s1 = s2;
                end
                {CL_UP, CL_DROP}, {CL_UP, CL_DOWN}, {CL_UP, CL_SAME}: begin
                    tcode = TC_ONE;
                    s0 = s1;
                    s2 = s1;
                end
                default: begin
                    // A dip followed by a small rise: all parts take the smaller outer index.
                    tcode = TC_ONE;
                    if (s0 > s2) begin
                        s0 = s2;
                    end
                    s1 = s0;
                    s2 = s0;
                end
            endcase
            // Band count of zero acts as one, and anything above the maximum as the maximum.
            lim = band_count;
            if (lim < 1) begin
                lim = 1;
            end
            if (lim > MAX_BANDS) begin
                lim = MAX_BANDS;
            end
            r.last   = (band_pos + 1 >= lim);
            band_pos = r.last ? 0 : ((band_pos + 1) & 31);
            sample_pos = 0;
            r.first  = s0;
            r.second = s1;
            r.third  = s2;
            r.code   = tcode;
            pending_bands.push_back(r);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_band_result(logic [23:0] data, logic last);
            band_res_t want;
            if (pending_bands.size() == 0) begin
                $error("band result with none pending: tdata=%h tlast=%b", data, last);
                errors++;
                return;
            end
            want = pending_bands.pop_front();
            compare("first_scale_index", want.first, data[5:0]);
            compare("second_scale_index", want.second, data[11:6]);
            compare("third_scale_index", want.third, data[17:12]);
            compare("transmit_code", want.code, data[19:18]);
            compare("last_band", want.last, last);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic [23:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_wr_en;
    logic [5:0]  cfg_wr_data;

    band_scale_tracker scale_track;
    int src_idle_pct;
    int dst_idle_pct;
    int cycle_count;

    subband_scale_factor_select_core #(
        .SAMPLE_BITS(SAMPLE_W),
        .MAX_BANDS  (MAX_BANDS)
    ) u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Sink stalls at random according to the current phase.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= dst_idle_pct);
    end

    // Check every accepted band result.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            scale_track.check_band_result(m_tdata, m_tlast);
        end
    end

    // Cycle limit guards against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[subband_scale_factor_select_core] ERROR");
            $finish;
        end
    end

    // Offer one sample, with random idle cycles ahead of it, and hold it until taken.
    task automatic drive_sample(input logic [23:0] v);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        scale_track.note_sample(v);
        @(negedge aclk);
    endtask

    task automatic wait_for_drain();
        while (scale_track.pending() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Band count writes happen only with no band in flight.
    task automatic write_band_count(input logic [5:0] v);
        s_tvalid = 1'b0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        scale_track.set_band_count(v);
    endtask

    // Twelve samples whose largest magnitude is exactly the given peak.
    task automatic send_part(input int unsigned peak);
        int unsigned at;
        int unsigned mag;
        logic [23:0] m24;
        at = $urandom_range(0, PART_LEN - 1);
        for (int k = 0; k < PART_LEN; k++) begin
            mag = (k == at) ? peak : $urandom_range(0, peak);
            m24 = mag[23:0];
            drive_sample($urandom_range(0, 1) ? -m24 : m24);
        end
    endtask

    // A peak that lands on or near the wanted scale factor index.
    function automatic int unsigned peak_for_index(input int unsigned idx);
        int unsigned lo;
        int unsigned hi;
        if (idx == ZERO_INDEX) begin
            return 0;
        end
        if (idx == 0) begin
            return $urandom_range(1 << OVER_BIT, 1 << (SAMPLE_W - 1));
        end
        lo = scale_track.thr_tab[idx + 1] + 1;
        hi = scale_track.thr_tab[idx];
        return (lo > hi) ? hi : $urandom_range(lo, hi);
    endfunction

    // Next index a few steps away from the previous one, or anywhere now and then.
    function automatic int unsigned near_index(input int unsigned idx);
        int v;
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(0, ZERO_INDEX);
        end
        v = int'(idx) + int'($urandom_range(0, 10)) - 5;
        if (v < 0) begin
            v = 0;
        end
        if (v > ZERO_INDEX) begin
            v = ZERO_INDEX;
        end
        return v;
    endfunction

    // One band of random shape: close indices, raw noise, or tiny values.
    task automatic send_random_band();
        int unsigned pick;
        int unsigned i0;
        int unsigned i1;
        int unsigned i2;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            i0 = $urandom_range(0, ZERO_INDEX);
            i1 = near_index(i0);
            i2 = near_index(i1);
            send_part(peak_for_index(i0));
            send_part(peak_for_index(i1));
            send_part(peak_for_index(i2));
        end else if (pick < 85) begin
            for (int k = 0; k < BAND_SAMPLES; k++) begin
                drive_sample(24'($urandom()));
            end
        end else begin
            for (int p = 0; p < 3; p++) begin
                send_part($urandom_range(0, 6));
            end
        end
    endtask

    initial begin
        logic [5:0] count_plan [PHASES*SEGMENTS];
        scale_track  = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        src_idle_pct = 0;
        dst_idle_pct = 0;
        cycle_count  = 0;
        count_plan = '{6'd32, 6'd0, 6'd1, 6'd63, 6'd3, 6'd33, 6'd2, 6'd31,
                       6'd5, 6'd0, 6'd0, 6'd4};
        count_plan[9]  = 6'($urandom_range(1, 32));
        count_plan[10] = 6'($urandom_range(0, 63));

        // Hold reset, then release at a falling edge.
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            // Sender idles little at first, then heavily, then not at all.
            src_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 54 : 0;
            dst_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 8 : 0;
            for (int sg = 0; sg < SEGMENTS; sg++) begin
                write_band_count(count_plan[ph * SEGMENTS + sg]);
                if (ph == 0 && sg == 0) begin
                    // All-zero parts, overflow from the most negative sample,
                    // peak of one at the refinement limit, extremes of the range.
                    send_part(0);
                    send_part(0);
                    send_part(0);
                    send_part(1 << (SAMPLE_W - 1));
                    send_part(1);
                    send_part(0);
                    send_part((1 << (SAMPLE_W - 1)) - 1);
                    send_part(1 << OVER_BIT);
                    send_part((1 << OVER_BIT) - 1);
                end
                repeat ($urandom_range(3, 5)) send_random_band();
            end
        end
        s_tvalid = 1'b0;

        // Let the last results come out, then report.
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (scale_track.errors == 0 && scale_track.pending() == 0) begin
            $display("[subband_scale_factor_select_core] OK");
        end else begin
            $display("[subband_scale_factor_select_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ssfs_pkg.sv
hdl/ssfs_front.sv
hdl/ssfs_queue.sv
hdl/ssfs_back.sv
hdl/subband_scale_factor_select_core.sv
bench/tb_subband_scale_factor_select_core.sv
